// ===== rtl/gamepad_report_conditioner_assert.svh =====
// Assertion macros for the gamepad report conditioner.
// Expects clk and rst_n in the scope of the including module.
`ifndef GAMEPAD_REPORT_CONDITIONER_ASSERT_SVH
`define GAMEPAD_REPORT_CONDITIONER_ASSERT_SVH

// Same-cycle implication under reset.
`define GRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/grc_pkg.sv =====
// Shared types and constants for the gamepad report conditioner.
// No dependencies.
`timescale 1ns / 1ps

package grc_pkg;

    localparam int PAD_SLOTS    = 4;
    localparam int BUTTON_COUNT = 15;
    localparam int SLOT_W       = 2;
    localparam int CNT_W        = 5;

    localparam logic [16:0] Q16_ONE    = 17'h10000;
    localparam logic [16:0] STICK_RST  = 17'd13107;
    localparam logic [16:0] TRIG_RST   = 17'd6554;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 5'd17;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd18;

    localparam logic [1:0] REG_STICK_ZONE = 2'd0;
    localparam logic [1:0] REG_TRIG_ZONE  = 2'd1;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic        start;
        arith_op_t   op;
        logic [47:0] num;
        logic [33:0] den;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [17:0] result;
    } arith_rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       pad_slot;
        logic                    present;
        logic [BUTTON_COUNT-1:0] raw_buttons;
        logic signed [15:0]      raw_left_x;
        logic signed [15:0]      raw_left_y;
        logic signed [15:0]      raw_right_x;
        logic signed [15:0]      raw_right_y;
        logic signed [15:0]      raw_left_trig;
        logic signed [15:0]      raw_right_trig;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       out_slot;
        logic                    connected;
        logic [BUTTON_COUNT-1:0] buttons_down;
        logic [BUTTON_COUNT-1:0] buttons_pressed;
        logic [BUTTON_COUNT-1:0] buttons_released;
        logic signed [15:0]      left_x;
        logic signed [15:0]      left_y;
        logic signed [15:0]      right_x;
        logic signed [15:0]      right_y;
        logic [15:0]             left_trig;
        logic [15:0]             right_trig;
    } out_t;

    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [15:0] left_trig;
        logic [15:0] right_trig;
    } axes_t;

endpackage

// ===== rtl/grc_arith.sv =====
// Shared square-root / divide unit, one result bit per cycle.
// Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_arith
    import grc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    arith_op_t        op_reg, op_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [34:0]      rem_reg, rem_next;
    logic [47:0]      work_reg, work_next;
    logic [17:0]      acc_reg, acc_next;
    logic [33:0]      den_reg, den_next;

    logic [34:0] cand;
    logic [34:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            cand  = {rem_reg[32:0], work_reg[47:46]};
            trial = {15'd0, acc_reg, 2'b01};
        end
        else
        begin
            cand  = {rem_reg[33:0], work_reg[47]};
            trial = {1'b0, den_reg};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[35];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        work_next  = work_reg;
        acc_next   = acc_reg;
        den_next   = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            den_next  = req.den;
            if (req.op == OP_SQRT)
            begin
                rem_next   = '0;
                work_next  = {req.num[33:0], 14'd0};
                count_next = SQRT_STEPS;
            end
            else
            begin
                rem_next   = {5'd0, req.num[47:18]};
                work_next  = {req.num[17:0], 30'd0};
                count_next = DIV_STEPS;
            end
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[34:0] : cand;
            acc_next   = {acc_reg[16:0], ge};
            work_next  = (op_reg == OP_SQRT) ? {work_reg[45:0], 2'b00}
                                             : {work_reg[46:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== rtl/grc_ctrl.sv =====
// Sequencer for the stick and trigger conditioning of one report.
// Depends on grc_pkg; drives grc_arith through its request struct.
`timescale 1ns / 1ps

module grc_ctrl
    import grc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        release_done,
    input  in_t         item,
    input  logic [16:0] stick_zone,
    input  logic [16:0] trig_zone,
    input  arith_rsp_t  rsp,
    output arith_req_t  req,
    output logic        done,
    output axes_t       axes
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQX   = 9'b000000010,
        ST_SQY   = 9'b000000100,
        ST_ROOT  = 9'b000001000,
        ST_DEN   = 9'b000010000,
        ST_NUM   = 9'b000100000,
        ST_CHK   = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  job_reg, job_next;
    logic [31:0] r2_reg, r2_next;
    logic [16:0] r16_reg, r16_next;
    logic [33:0] den_reg, den_next;
    logic [47:0] num_reg, num_next;
    logic        zero_reg, zero_next;
    logic        ovf_reg, ovf_next;
    logic [17:0] q_reg, q_next;
    logic        store;
    logic [15:0] res_reg [0:5];
    logic [15:0] res_val;

    logic [15:0] sx, sy, ax, ay, av, amag, traw, tval;
    logic [16:0] mul_a, mul_b, c16, cmz, dtrig, tmz;
    logic [33:0] prod;
    logic [31:0] r2_sum;

    always_comb
    begin
        sx   = job_reg[1] ? item.raw_right_x : item.raw_left_x;
        sy   = job_reg[1] ? item.raw_right_y : item.raw_left_y;
        ax   = sx[15] ? (~sx + 16'd1) : sx;
        ay   = sy[15] ? (~sy + 16'd1) : sy;
        av   = job_reg[0] ? sy : sx;
        amag = job_reg[0] ? ay : ax;
        traw = job_reg[0] ? item.raw_right_trig : item.raw_left_trig;
        tval = {~traw[15], traw[14:0]};
        c16  = (r16_reg > Q16_ONE) ? Q16_ONE : r16_reg;
        cmz  = c16 - stick_zone;
        dtrig = Q16_ONE - trig_zone;
        tmz  = {1'b0, tval} - trig_zone;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = {1'b0, ax};
                mul_b = {1'b0, ax};
            end
            ST_SQY:
            begin
                mul_a = {1'b0, ay};
                mul_b = {1'b0, ay};
            end
            ST_DEN:
            begin
                mul_a = Q16_ONE - stick_zone;
                mul_b = r16_reg;
            end
            default:
            begin
                mul_a = {1'b0, amag};
                mul_b = cmz;
            end
        endcase
        prod   = mul_a * mul_b;
        r2_sum = r2_reg + prod[31:0];
    end

    always_comb
    begin
        if (job_reg[2])
            res_val = (ovf_reg || q_reg > 18'd65535) ? 16'hFFFF : q_reg[15:0];
        else if (av[15])
            res_val = (ovf_reg || q_reg > 18'd32768) ? 16'h8000 : (~q_reg[15:0] + 16'd1);
        else
            res_val = (ovf_reg || q_reg > 18'd32767) ? 16'h7FFF : q_reg[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        r2_next    = r2_reg;
        r16_next   = r16_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        zero_next  = zero_reg;
        ovf_next   = ovf_reg;
        q_next     = q_reg;
        store      = 1'b0;
        req.start  = 1'b0;
        req.op     = OP_DIV;
        req.num    = num_reg;
        req.den    = den_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    job_next   = 3'd0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                r2_next    = prod[31:0];
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                req.start  = 1'b1;
                req.op     = OP_SQRT;
                req.num    = {14'd0, r2_sum, 2'b00};
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rsp.done)
                begin
                    r16_next   = rsp.result[16:0];
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                den_next   = prod;
                zero_next  = stick_zone[16] || (r16_reg <= stick_zone);
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                if (job_reg[2])
                begin
                    den_next  = {17'd0, dtrig};
                    zero_next = trig_zone[16] || ({1'b0, tval} <= trig_zone);
                    num_next  = {15'd0, tmz, 16'd0} + {32'd0, dtrig[16:1]};
                end
                else
                    num_next = {prod[31:0], 16'd0} + {15'd0, den_reg[33:1]};
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                q_next   = '0;
                ovf_next = 1'b0;
                if (zero_reg)
                    state_next = ST_DIV;
                else if ({4'd0, num_reg[47:18]} >= den_reg)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (zero_reg || ovf_reg || rsp.done)
                begin
                    if (rsp.done)
                        q_next = rsp.result;
                    store    = 1'b1;
                    job_next = job_reg + 3'd1;
                    if (job_reg == 3'd5)
                        state_next = ST_DONE;
                    else if (job_reg == 3'd1)
                        state_next = ST_SQX;
                    else
                        state_next = ST_NUM;
                end
            end
            ST_DONE:
            begin
                if (release_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Division result lands with the done pulse; take it straight into the store.
    logic [15:0] store_val;
    always_comb
    begin
        if (rsp.done && !zero_reg && !ovf_reg)
        begin
            if (job_reg[2])
                store_val = (rsp.result > 18'd65535) ? 16'hFFFF : rsp.result[15:0];
            else if (av[15])
                store_val = (rsp.result > 18'd32768) ? 16'h8000
                                                     : (~rsp.result[15:0] + 16'd1);
            else
                store_val = (rsp.result > 18'd32767) ? 16'h7FFF : rsp.result[15:0];
        end
        else
            store_val = res_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg   <= r2_next;
        r16_reg  <= r16_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        q_reg    <= q_next;
        if (store)
            res_reg[job_reg] <= store_val;
    end

    assign done             = (state_reg == ST_DONE);
    assign axes.left_x      = res_reg[0];
    assign axes.left_y      = res_reg[1];
    assign axes.right_x     = res_reg[2];
    assign axes.right_y     = res_reg[3];
    assign axes.left_trig   = res_reg[4];
    assign axes.right_trig  = res_reg[5];

endmodule

// ===== rtl/gamepad_report_conditioner.sv =====
// Gamepad report conditioner: one report beat in, one conditioned beat out, per pad slot.
// An absent pad yields a result with zeros except released buttons and the slot.
// Each report runs two roots and up to six quotients, one after another, on the shared
// square-root/divide unit, which yields one result bit per cycle, with 17 steps per root
// and 18 per quotient. Each stick or trigger value that falls inside its dead zone, or
// saturates, skips its quotient.
// in_ready stays low from an accepted beat until its result is loaded into the output register.
// Depends on grc_pkg, grc_arith, grc_ctrl and gamepad_report_conditioner_assert.svh.
`timescale 1ns / 1ps

module gamepad_report_conditioner
    import grc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

`include "gamepad_report_conditioner_assert.svh"

    logic [16:0] stick_zone_reg, trig_zone_reg;
    logic        conn_reg [0:PAD_SLOTS-1];
    logic [BUTTON_COUNT-1:0] held_reg [0:PAD_SLOTS-1];

    logic        busy_reg;
    logic        start_reg;
    in_t         item_reg;
    logic        conn_o_reg;
    logic [BUTTON_COUNT-1:0] down_reg, pressed_reg, released_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic        in_accept, out_load, ctrl_done;
    logic [BUTTON_COUNT-1:0] prev;
    arith_req_t  req;
    arith_rsp_t  rsp;
    axes_t       axes;

    assign in_ready  = ~busy_reg;
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid & in_ready;
    assign out_load  = ctrl_done & (~out_valid_reg | out_ready);
    assign prev      = held_reg[in_data.pad_slot];

    grc_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp)
    );

    grc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start_reg),
        .release_done (out_load),
        .item         (item_reg),
        .stick_zone   (stick_zone_reg),
        .trig_zone    (trig_zone_reg),
        .rsp          (rsp),
        .req          (req),
        .done         (ctrl_done),
        .axes         (axes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_zone_reg <= STICK_RST;
            trig_zone_reg  <= TRIG_RST;
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < PAD_SLOTS; i++)
            begin
                conn_reg[i] <= 1'b0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            start_reg <= in_accept;
            if (cfg_valid && cfg_index == REG_STICK_ZONE)
                stick_zone_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_TRIG_ZONE)
                trig_zone_reg <= cfg_data;
            if (in_accept)
            begin
                busy_reg <= 1'b1;
                if (in_data.present)
                begin
                    held_reg[in_data.pad_slot] <= in_data.raw_buttons;
                    conn_reg[in_data.pad_slot] <= 1'b1;
                end
                else
                begin
                    held_reg[in_data.pad_slot] <= '0;
                    conn_reg[in_data.pad_slot] <= 1'b0;
                end
            end
            else if (out_load)
                busy_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg   <= in_data;
            conn_o_reg <= in_data.present;
            if (in_data.present)
            begin
                down_reg <= in_data.raw_buttons;
                if (conn_reg[in_data.pad_slot])
                begin
                    pressed_reg  <= in_data.raw_buttons & ~prev;
                    released_reg <= prev & ~in_data.raw_buttons;
                end
                else
                begin
                    pressed_reg  <= '0;
                    released_reg <= '0;
                end
            end
            else
            begin
                down_reg     <= '0;
                pressed_reg  <= '0;
                released_reg <= prev;
            end
        end
        if (out_load)
        begin
            out_reg.out_slot         <= item_reg.pad_slot;
            out_reg.connected        <= conn_o_reg;
            out_reg.buttons_down     <= down_reg;
            out_reg.buttons_pressed  <= pressed_reg;
            out_reg.buttons_released <= released_reg;
            out_reg.left_x     <= conn_o_reg ? axes.left_x     : 16'd0;
            out_reg.left_y     <= conn_o_reg ? axes.left_y     : 16'd0;
            out_reg.right_x    <= conn_o_reg ? axes.right_x    : 16'd0;
            out_reg.right_y    <= conn_o_reg ? axes.right_y    : 16'd0;
            out_reg.left_trig  <= conn_o_reg ? axes.left_trig  : 16'd0;
            out_reg.right_trig <= conn_o_reg ? axes.right_trig : 16'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GRC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input accepted while a report is still in work")
    `GRC_ASSERT_NOW(a_absent_at_rest, out_valid && !out_data.connected,
        out_data.buttons_down == '0 && out_data.left_trig == '0 && out_data.right_x == '0,
        "absent pad reports motion")
    `GRC_ASSERT_NOW(a_edges_disjoint, out_valid,
        (out_data.buttons_pressed & out_data.buttons_released) == '0,
        "button pressed and released in one beat")
    `GRC_ASSERT_NOW(a_pressed_held, out_valid,
        (out_data.buttons_pressed & ~out_data.buttons_down) == '0,
        "pressed button not held")

endmodule
